/* hw/rtl/tcc_pkg.sv */
package tcc_pkg;

	// Coordinate format: signed, raw units. The fraction scale cancels in the
	// quotient, so only the total width shapes the datapath.
	localparam int COORD_W = 32;

	// Corner differences carry one extra bit.
	localparam int A_W    = COORD_W + 1;
	localparam int PROD_W = 2 * A_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DEN_W  = PROD_W + 2;
	localparam int LEN_W  = PROD_W + 1;
	localparam int HI_W   = LEN_W - A_W;
	localparam int PP_W   = 2 * A_W + 1;
	localparam int NUM_W  = 3 * A_W + 2;

	// Divider operands: dividend 2|n| + |d|, divisor 2|d|.
	localparam int N_W    = NUM_W + 1;
	localparam int DD_W   = DEN_W + 1;
	localparam int Q_W    = COORD_W + 2;
	localparam int REM_W  = DD_W + 1;
	localparam int SUM_W  = Q_W + 2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEGEN = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	// Side information that travels alongside the divider.
	typedef struct packed {
		logic               degen;
		logic               neg_x;
		logic               neg_y;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
	} tcc_tag_t;

endpackage

/* hw/rtl/triangle_circumcenter.sv */
// Channel   Handshake        Ports
// command   start, busy      first_x, first_y, second_x, second_y, third_x, third_y
// result    done (strobe)    center_x, center_y, status
//
// A transaction is accepted on every edge where start is high; busy never rises, so a
// new triangle may enter in every cycle. Each result passes through the product and
// numerator pipeline, then the bit-per-stage divider, then a registered output stage
// that applies the sign, adds the offset and clamps.
// Reset clears only the valid bits of the pipeline. The receiver cannot stall.
module triangle_circumcenter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tcc_pkg::COORD_W-1:0]  first_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  first_y,
	input  logic signed [tcc_pkg::COORD_W-1:0]  second_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  second_y,
	input  logic signed [tcc_pkg::COORD_W-1:0]  third_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  third_y,
	output logic                                done,
	output logic signed [tcc_pkg::COORD_W-1:0]  center_x,
	output logic signed [tcc_pkg::COORD_W-1:0]  center_y,
	output logic [1:0]                          status
);
	import tcc_pkg::*;

	logic             fr_valid;
	logic [N_W-1:0]   fr_num_x, fr_num_y;
	logic [DD_W-1:0]  fr_dvs;
	tcc_tag_t         fr_tag;

	logic             dv_valid;
	logic [Q_W-1:0]   dv_quo_x, dv_quo_y;
	logic             dv_ovf_x, dv_ovf_y;
	tcc_tag_t         dv_tag;

	// The pipeline never holds anything back, so the command side is always open.
	assign busy = 1'b0;

	// Differences, products, and the two rounded dividend/divisor pairs.
	tcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.third_x   (third_x),
		.third_y   (third_y),
		.out_valid (fr_valid),
		.num_x     (fr_num_x),
		.num_y     (fr_num_y),
		.dvs       (fr_dvs),
		.tag       (fr_tag)
	);

	// Quotient magnitudes; an overflow flag marks any quotient of 2^Q_W or more, which
	// does not fit the quotient width.
	tcc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.num_x     (fr_num_x),
		.num_y     (fr_num_y),
		.dvs       (fr_dvs),
		.in_tag    (fr_tag),
		.out_valid (dv_valid),
		.quo_x     (dv_quo_x),
		.quo_y     (dv_quo_y),
		.ovf_x     (dv_ovf_x),
		.ovf_y     (dv_ovf_y),
		.out_tag   (dv_tag)
	);

	// Apply signs, add the first corner, clamp, and build the status code.
	tcc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.quo_x    (dv_quo_x),
		.quo_y    (dv_quo_y),
		.ovf_x    (dv_ovf_x),
		.ovf_y    (dv_ovf_y),
		.in_tag   (dv_tag),
		.done     (done),
		.center_x (center_x),
		.center_y (center_y),
		.status   (status)
	);

endmodule

/* hw/rtl/tcc_front.sv */
module tcc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [tcc_pkg::COORD_W-1:0]  first_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  first_y,
	input  logic signed [tcc_pkg::COORD_W-1:0]  second_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  second_y,
	input  logic signed [tcc_pkg::COORD_W-1:0]  third_x,
	input  logic signed [tcc_pkg::COORD_W-1:0]  third_y,
	output logic                                out_valid,
	output logic [tcc_pkg::N_W-1:0]             num_x,
	output logic [tcc_pkg::N_W-1:0]             num_y,
	output logic [tcc_pkg::DD_W-1:0]            dvs,
	output tcc_pkg::tcc_tag_t                   tag
);
	import tcc_pkg::*;

	function automatic logic signed [PP_W-1:0] mul_lo(input logic signed [A_W-1:0] a,
			input logic signed [LEN_W-1:0] l);
		return PP_W'(a) * PP_W'($signed({1'b0, l[A_W-1:0]}));
	endfunction

	function automatic logic signed [PP_W-1:0] mul_hi(input logic signed [A_W-1:0] a,
			input logic signed [LEN_W-1:0] l);
		return PP_W'(a) * PP_W'($signed(l[LEN_W-1:A_W]));
	endfunction

	function automatic logic signed [NUM_W-1:0] join_pp(input logic signed [PP_W-1:0] hi,
			input logic signed [PP_W-1:0] lo);
		return (NUM_W'(hi) <<< A_W) + NUM_W'(lo);
	endfunction

	logic [8:1] v_s;

	logic signed [A_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [A_W-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [A_W-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic [COORD_W-1:0] x0_s1, y0_s1, x0_s2, y0_s2, x0_s3, y0_s3, x0_s4, y0_s4;
	logic [COORD_W-1:0] x0_s5, y0_s5, x0_s6, y0_s6, x0_s7, y0_s7, x0_s8, y0_s8;

	logic signed [PROD_W-1:0] pab_s2, pba_s2, paa_s2, pay_s2, pbx_s2, pby_s2;
	logic signed [CROSS_W-1:0] cross_s3;
	logic signed [LEN_W-1:0] la_s3, lb_s3;

	logic signed [DEN_W-1:0] den_s4, den_s5, den_s6;
	logic degen_s4, degen_s5, degen_s6, degen_s7, degen_s8;
	logic signed [PP_W-1:0] p1h_s4, p1l_s4, p2h_s4, p2l_s4, p3h_s4, p3l_s4, p4h_s4, p4l_s4;

	logic signed [NUM_W-1:0] t1_s5, t2_s5, t3_s5, t4_s5;
	logic signed [NUM_W-1:0] nx_s6, ny_s6;

	logic [NUM_W-1:0] anx_s7, any_s7;
	logic [DEN_W-1:0] aden_s7;
	logic negx_s7, negy_s7, negx_s8, negy_s8;

	logic [N_W-1:0] nx_s8, ny_s8;
	logic [DD_W-1:0] dd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[7:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// Corner differences.
		ax_s1 <= A_W'(second_x) - A_W'(first_x);
		ay_s1 <= A_W'(second_y) - A_W'(first_y);
		bx_s1 <= A_W'(third_x) - A_W'(first_x);
		by_s1 <= A_W'(third_y) - A_W'(first_y);
		x0_s1 <= first_x;
		y0_s1 <= first_y;

		// Squares and cross products.
		pab_s2 <= PROD_W'(ax_s1) * PROD_W'(by_s1);
		pba_s2 <= PROD_W'(ay_s1) * PROD_W'(bx_s1);
		paa_s2 <= PROD_W'(ax_s1) * PROD_W'(ax_s1);
		pay_s2 <= PROD_W'(ay_s1) * PROD_W'(ay_s1);
		pbx_s2 <= PROD_W'(bx_s1) * PROD_W'(bx_s1);
		pby_s2 <= PROD_W'(by_s1) * PROD_W'(by_s1);
		{ax_s2, ay_s2, bx_s2, by_s2} <= {ax_s1, ay_s1, bx_s1, by_s1};
		{x0_s2, y0_s2} <= {x0_s1, y0_s1};

		cross_s3 <= CROSS_W'(pab_s2) - CROSS_W'(pba_s2);
		la_s3 <= LEN_W'(paa_s2) + LEN_W'(pay_s2);
		lb_s3 <= LEN_W'(pbx_s2) + LEN_W'(pby_s2);
		{ax_s3, ay_s3, bx_s3, by_s3} <= {ax_s2, ay_s2, bx_s2, by_s2};
		{x0_s3, y0_s3} <= {x0_s2, y0_s2};

		// Wide products are split in two halves of the squared length.
		den_s4 <= DEN_W'(cross_s3) <<< 1;
		degen_s4 <= (cross_s3 == '0);
		p1h_s4 <= mul_hi(by_s3, la_s3);
		p1l_s4 <= mul_lo(by_s3, la_s3);
		p2h_s4 <= mul_hi(ay_s3, lb_s3);
		p2l_s4 <= mul_lo(ay_s3, lb_s3);
		p3h_s4 <= mul_hi(ax_s3, lb_s3);
		p3l_s4 <= mul_lo(ax_s3, lb_s3);
		p4h_s4 <= mul_hi(bx_s3, la_s3);
		p4l_s4 <= mul_lo(bx_s3, la_s3);
		{x0_s4, y0_s4} <= {x0_s3, y0_s3};

		t1_s5 <= join_pp(p1h_s4, p1l_s4);
		t2_s5 <= join_pp(p2h_s4, p2l_s4);
		t3_s5 <= join_pp(p3h_s4, p3l_s4);
		t4_s5 <= join_pp(p4h_s4, p4l_s4);
		den_s5 <= den_s4;
		degen_s5 <= degen_s4;
		{x0_s5, y0_s5} <= {x0_s4, y0_s4};

		nx_s6 <= t1_s5 - t2_s5;
		ny_s6 <= t3_s5 - t4_s5;
		den_s6 <= den_s5;
		degen_s6 <= degen_s5;
		{x0_s6, y0_s6} <= {x0_s5, y0_s5};

		// Magnitudes and the sign of each quotient.
		anx_s7 <= nx_s6[NUM_W-1] ? $unsigned(-nx_s6) : $unsigned(nx_s6);
		any_s7 <= ny_s6[NUM_W-1] ? $unsigned(-ny_s6) : $unsigned(ny_s6);
		aden_s7 <= den_s6[DEN_W-1] ? $unsigned(-den_s6) : $unsigned(den_s6);
		negx_s7 <= nx_s6[NUM_W-1] ^ den_s6[DEN_W-1];
		negy_s7 <= ny_s6[NUM_W-1] ^ den_s6[DEN_W-1];
		degen_s7 <= degen_s6;
		{x0_s7, y0_s7} <= {x0_s6, y0_s6};

		// Round to nearest: (2|n| + |d|) / (2|d|).
		nx_s8 <= {anx_s7, 1'b0} + N_W'(aden_s7);
		ny_s8 <= {any_s7, 1'b0} + N_W'(aden_s7);
		dd_s8 <= {aden_s7, 1'b0};
		negx_s8 <= negx_s7;
		negy_s8 <= negy_s7;
		degen_s8 <= degen_s7;
		{x0_s8, y0_s8} <= {x0_s7, y0_s7};
	end

	assign out_valid = v_s[8];
	assign num_x = nx_s8;
	assign num_y = ny_s8;
	assign dvs = dd_s8;
	assign tag = '{degen: degen_s8, neg_x: negx_s8, neg_y: negy_s8, x0: x0_s8, y0: y0_s8};

endmodule

/* hw/rtl/tcc_div.sv */
module tcc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tcc_pkg::N_W-1:0]    num_x,
	input  logic [tcc_pkg::N_W-1:0]    num_y,
	input  logic [tcc_pkg::DD_W-1:0]   dvs,
	input  tcc_pkg::tcc_tag_t          in_tag,
	output logic                       out_valid,
	output logic [tcc_pkg::Q_W-1:0]    quo_x,
	output logic [tcc_pkg::Q_W-1:0]    quo_y,
	output logic                       ovf_x,
	output logic                       ovf_y,
	output tcc_pkg::tcc_tag_t          out_tag
);
	import tcc_pkg::*;

	// Restoring division, one quotient bit per stage for both axes.
	// Stage 0 yields no quotient bit; it loads the operands and checks whether the quotient reaches 2^Q_W.
	logic [Q_W:0]       v_s;
	logic [REM_W-1:0]   remx_s [0:Q_W];
	logic [REM_W-1:0]   remy_s [0:Q_W];
	logic [Q_W-1:0]     lox_s  [0:Q_W];
	logic [Q_W-1:0]     loy_s  [0:Q_W];
	logic [Q_W-1:0]     qx_s   [0:Q_W];
	logic [Q_W-1:0]     qy_s   [0:Q_W];
	logic [DD_W-1:0]    dd_s   [0:Q_W];
	logic               ovx_s  [0:Q_W];
	logic               ovy_s  [0:Q_W];
	tcc_tag_t           tag_s  [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[Q_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		remx_s[0] <= REM_W'(num_x[N_W-1:Q_W]);
		remy_s[0] <= REM_W'(num_y[N_W-1:Q_W]);
		ovx_s[0] <= (REM_W'(num_x[N_W-1:Q_W]) >= REM_W'(dvs));
		ovy_s[0] <= (REM_W'(num_y[N_W-1:Q_W]) >= REM_W'(dvs));
		lox_s[0] <= num_x[Q_W-1:0];
		loy_s[0] <= num_y[Q_W-1:0];
		qx_s[0] <= '0;
		qy_s[0] <= '0;
		dd_s[0] <= dvs;
		tag_s[0] <= in_tag;
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [REM_W-1:0] tx, ty;
		logic gx, gy;

		always_comb begin
			tx = {remx_s[k-1][REM_W-2:0], lox_s[k-1][Q_W-1]};
			ty = {remy_s[k-1][REM_W-2:0], loy_s[k-1][Q_W-1]};
			gx = (tx >= REM_W'(dd_s[k-1]));
			gy = (ty >= REM_W'(dd_s[k-1]));
		end

		always_ff @(posedge clk) begin
			remx_s[k] <= gx ? tx - REM_W'(dd_s[k-1]) : tx;
			remy_s[k] <= gy ? ty - REM_W'(dd_s[k-1]) : ty;
			lox_s[k] <= {lox_s[k-1][Q_W-2:0], 1'b0};
			loy_s[k] <= {loy_s[k-1][Q_W-2:0], 1'b0};
			qx_s[k] <= {qx_s[k-1][Q_W-2:0], gx};
			qy_s[k] <= {qy_s[k-1][Q_W-2:0], gy};
			dd_s[k] <= dd_s[k-1];
			ovx_s[k] <= ovx_s[k-1];
			ovy_s[k] <= ovy_s[k-1];
			tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_valid = v_s[Q_W];
	assign quo_x = qx_s[Q_W];
	assign quo_y = qy_s[Q_W];
	assign ovf_x = ovx_s[Q_W];
	assign ovf_y = ovy_s[Q_W];
	assign out_tag = tag_s[Q_W];

endmodule

/* hw/rtl/tcc_out.sv */
module tcc_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [tcc_pkg::Q_W-1:0]       quo_x,
	input  logic [tcc_pkg::Q_W-1:0]       quo_y,
	input  logic                          ovf_x,
	input  logic                          ovf_y,
	input  tcc_pkg::tcc_tag_t             in_tag,
	output logic                          done,
	output logic signed [tcc_pkg::COORD_W-1:0] center_x,
	output logic signed [tcc_pkg::COORD_W-1:0] center_y,
	output logic [1:0]                    status
);
	import tcc_pkg::*;

	localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Returns {saturated, coordinate}.
	function automatic logic [COORD_W:0] place(input logic [COORD_W-1:0] base,
			input logic [Q_W-1:0] q, input logic neg, input logic ovf);
		logic signed [SUM_W-1:0] qs;
		logic signed [SUM_W-1:0] sum;
		logic fits;
		qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		sum = SUM_W'($signed(base)) + qs;
		fits = (sum[SUM_W-1:COORD_W-1] == '0) || (sum[SUM_W-1:COORD_W-1] == '1);
		if (ovf) begin
			return {1'b1, neg ? C_MIN : C_MAX};
		end else if (!fits) begin
			return {1'b1, sum[SUM_W-1] ? C_MIN : C_MAX};
		end else begin
			return {1'b0, sum[COORD_W-1:0]};
		end
	endfunction

	logic [COORD_W:0] px, py;
	status_t st;
	logic done_q;
	logic [COORD_W-1:0] cx_q, cy_q;
	status_t st_q;

	always_comb begin
		px = place(in_tag.x0, quo_x, in_tag.neg_x, ovf_x);
		py = place(in_tag.y0, quo_y, in_tag.neg_y, ovf_y);
		if (in_tag.degen) begin
			st = ST_DEGEN;
		end else if (px[COORD_W] || py[COORD_W]) begin
			st = ST_SAT;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cx_q <= in_tag.degen ? '0 : px[COORD_W-1:0];
		cy_q <= in_tag.degen ? '0 : py[COORD_W-1:0];
		st_q <= st;
	end

	assign done = done_q;
	assign center_x = $signed(cx_q);
	assign center_y = $signed(cy_q);
	assign status = st_q;

endmodule

/* dv/triangle_circumcenter_test.sv */
`timescale 1ns / 100ps

// Testbench for triangle_circumcenter.
// Triangles go in as command transactions; a predictor computes the exact
// circumcenter with wide signed arithmetic and rounding to nearest (ties
// away from zero), then clamps it, and queues the expected transaction.
// A monitor compares every done strobe against the oldest expectation.
module triangle_circumcenter_test;
	import tcc_pkg::*;

	localparam int LATENCY = 44;

	// The wide type holds every intermediate value exactly.
	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		status_t                   st;
	} center_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
	logic                      done;
	logic signed [COORD_W-1:0] center_x, center_y;
	logic [1:0]                status;

	center_t expected_centers[$];
	int      error_count;
	bit      allow_idle;

	triangle_circumcenter u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y),
		.third_x(third_x), .third_y(third_y),
		.done(done), .center_x(center_x), .center_y(center_y), .status(status)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Divides and rounds half away from zero; den is never zero here.
	function automatic wide_t div_round(wide_t num, wide_t den);
		wide_t an, ad, q;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	// Clamps one coordinate to the signed port range and flags saturation.
	function automatic logic signed [COORD_W-1:0] clamp_coord(wide_t v, ref bit sat);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
		lo = -(wide_t'(1) <<< (COORD_W - 1));
		if (v > hi) begin
			sat = 1'b1;
			return hi[COORD_W-1:0];
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic center_t predict_center(logic signed [COORD_W-1:0] x0, y0, x1, y1,
			x2, y2);
		wide_t ax, ay, bx, by, den, la, lb, nx, ny;
		center_t c;
		bit sat;
		sat = 1'b0;
		ax = wide_t'(x1) - wide_t'(x0);
		ay = wide_t'(y1) - wide_t'(y0);
		bx = wide_t'(x2) - wide_t'(x0);
		by = wide_t'(y2) - wide_t'(y0);
		den = 2 * (ax * by - ay * bx);
		if (den == 0) begin
			c.cx = '0;
			c.cy = '0;
			c.st = ST_DEGEN;
			return c;
		end
		la = ax * ax + ay * ay;
		lb = bx * bx + by * by;
		nx = by * la - ay * lb;
		ny = ax * lb - bx * la;
		c.cx = clamp_coord(wide_t'(x0) + div_round(nx, den), sat);
		c.cy = clamp_coord(wide_t'(y0) + div_round(ny, den), sat);
		c.st = sat ? ST_SAT : ST_OK;
		return c;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Sends one triangle, with a random idle burst ahead of it at times.
	task automatic send_triangle(logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2);
		int gap;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		first_x <= x0;  first_y <= y0;
		second_x <= x1; second_y <= y1;
		third_x <= x2;  third_y <= y2;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_centers.push_back(predict_center(x0, y0, x1, y1, x2, y2));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_centers.size() != 0) @(posedge clk);
	endtask

	// The monitor samples at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		center_t e;
		if (arst_n && done) begin
			if (expected_centers.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = expected_centers.pop_front();
				if (center_x !== e.cx)
					report_mismatch($sformatf("center_x %0d, want %0d", center_x, e.cx));
				if (center_y !== e.cy)
					report_mismatch($sformatf("center_y %0d, want %0d", center_y, e.cy));
				if (status !== e.st)
					report_mismatch($sformatf("status %0d, want %0d", status, e.st));
			end
		end
	end

	localparam logic signed [COORD_W-1:0] MAXC = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] MINC = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;

	// Directed corners: the three bisector cases, degenerate shapes, extremes.
	task automatic test_directed();
		send_triangle(0, 0, ONE, 0, 0, ONE);             // vertical and horizontal sides
		send_triangle(0, 0, 2 * ONE, 0, ONE, 3 * ONE);   // one side horizontal
		send_triangle(ONE, 2 * ONE, 3 * ONE, -ONE, -5 * ONE, 7 * ONE); // general
		send_triangle(5, 5, 5, 5, 5, 5);                 // coincident corners
		send_triangle(0, 0, ONE, ONE, 2 * ONE, 2 * ONE); // collinear corners
		send_triangle(0, 0, 1, 0, 0, 1);                 // smallest right triangle
		send_triangle(0, 0, 3, 0, 0, 1);                 // half-unit tie
		send_triangle(0, 0, -3, 0, 0, -1);               // negative tie
		send_triangle(MAXC, MAXC, MINC, MINC, MAXC, MINC);
		send_triangle(MINC, MINC, MAXC, MINC, MINC, MAXC);
		send_triangle(MAXC, 0, MAXC, 1, MAXC - 1, 0);
		send_triangle(0, 0, 1, 0, MAXC, 1);              // thin triangle, saturates
		send_triangle(0, 0, -1, 0, MINC, 1);
		send_triangle(MINC, MAXC, MAXC, MINC, 0, 0);     // nearly collinear, one corner at origin
		send_triangle(-1, -1, -1, -1, 0, 0);
		send_triangle(MINC, MINC, MINC + 1, MINC, MINC, MINC + 1);
	endtask

	// Full-range and modest triangles in equal share, plus some small ones.
	task automatic test_random(int count);
		logic signed [COORD_W-1:0] p[6];
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			foreach (p[k]) begin
				if (kind < 4)
					p[k] = $urandom();
				else if (kind < 8)
					p[k] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
				else
					p[k] = $signed($urandom_range(0, 16)) - 8;
			end
			if (kind == 9 && $urandom_range(0, 1)) begin
				// Collinear or coincident corners with random offsets.
				p[4] = p[0] + 2 * (p[2] - p[0]);
				p[5] = p[1] + 2 * (p[3] - p[1]);
			end
			send_triangle(p[0], p[1], p[2], p[3], p[4], p[5]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		{first_x, first_y, second_x, second_y, third_x, third_y} = '0;
		error_count = 0;
		allow_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();          // the sender holds off until all results are back
		allow_idle = 1'b1;
		test_random(800);
		allow_idle = 1'b0;       // back-to-back stream to finish
		test_random(200);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#200000;
		$display("Verification failed");
		$finish;
	end
endmodule
